// File: hw/rtl/evs_pkg.sv
package evs_pkg;

	// Default frame length in samples
	localparam int unsigned FRAME_SAMPLES_DEF = 480;

	// Payload widths
	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned MAG_W    = 16;
	localparam int unsigned SQ_W     = 31;
	localparam int unsigned THR_W    = 31;
	localparam int unsigned CNT_W    = 20;
	localparam int unsigned EV_W     = 3;

	// Configuration port
	localparam int unsigned CFG_DATA_W = THR_W;
	localparam int unsigned REG_IDX_W  = 2;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_ENERGY_THRESHOLD = 2'd0,
		REG_SILENCE_SAMPLES  = 2'd1,
		REG_MAX_SEGMENT      = 2'd2,
		REG_MIN_SEGMENT      = 2'd3
	} reg_index_t;

	localparam logic [THR_W-1:0] THRESHOLD_RST   = 31'd107374;
	localparam logic [CNT_W-1:0] SILENCE_RST     = 20'd16000;
	localparam logic [CNT_W-1:0] MAX_SEGMENT_RST = 20'd480000;
	localparam logic [CNT_W-1:0] MIN_SEGMENT_RST = 20'd8000;

	typedef enum logic [EV_W-1:0] {
		EV_IDLE      = 3'd0,
		EV_ONSET     = 3'd1,
		EV_RECORDING = 3'd2,
		EV_READY     = 3'd3,
		EV_SHORT     = 3'd4,
		EV_MAXLEN    = 3'd5
	} event_t;

	// Result queue
	localparam int unsigned FIFO_DEPTH = 8;
	localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int unsigned OCC_W      = $clog2(FIFO_DEPTH + 1);

	typedef struct packed {
		event_t             event_res;
		logic               frame_is_speech;
		logic [CNT_W-1:0]   segment_length;
	} result_t;

endpackage

// File: hw/rtl/evs_in_if.sv
interface evs_in_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [evs_pkg::SAMPLE_W-1:0]   sample;
	logic                                  frame_end;

	modport source (output valid, output sample, output frame_end, input ready);
	modport sink (input valid, input sample, input frame_end, output ready);
endinterface

// File: hw/rtl/evs_out_if.sv
interface evs_out_if;
	logic                          valid;
	logic                          ready;
	evs_pkg::event_t               event_res;
	logic                          frame_is_speech;
	logic [evs_pkg::CNT_W-1:0]     segment_length;

	modport source (output valid, output event_res, output frame_is_speech,
		output segment_length, input ready);
	modport sink (input valid, input event_res, input frame_is_speech,
		input segment_length, output ready);
endinterface

// File: hw/rtl/energy_vad_segmenter.sv
// Energy-based voice activity segmenter. Signed 16-bit samples enter on the audio channel, one
// transfer per clock, and a frame closes on a sample with frame_end set or on its FRAME_SAMPLES-th
// sample. Each closed frame yields exactly one transfer on the result channel (idle, onset,
// recording, segment ready, too short or maximum length, with the speech flag and the segment
// length); samples that do not close a frame yield nothing. The block sustains one sample per
// cycle. Each closing sample passes in turn through the input register, squarer,
// accumulator, threshold multiplier, energy compare and segment state update. Results wait in an
// eight-entry queue; audio.ready falls only when every queue slot is spoken for by a result
// already queued or by a sample still in flight, so a stalled consumer holds the stream back but
// a prompt one never does. No clearing pass is needed after reset. Registers are written through
// cfg_we, cfg_index and cfg_data and should only be changed while no frame is being processed.

module energy_vad_segmenter #(
	parameter int unsigned FRAME_SAMPLES = evs_pkg::FRAME_SAMPLES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [evs_pkg::REG_IDX_W-1:0]       cfg_index,
	input  logic [evs_pkg::CFG_DATA_W-1:0]      cfg_data,
	evs_in_if.sink                              audio,
	evs_out_if.source                           result
);

	localparam int unsigned CNT_W   = evs_pkg::CNT_W;
	localparam int unsigned THR_W   = evs_pkg::THR_W;
	localparam int unsigned SQ_W    = evs_pkg::SQ_W;
	localparam int unsigned MAG_W   = evs_pkg::MAG_W;
	localparam int unsigned OCC_W   = evs_pkg::OCC_W;
	localparam int unsigned FIFO_AW = evs_pkg::FIFO_AW;
	// Frame counter holds up to FRAME_SAMPLES; the sum holds FRAME_SAMPLES squares of 2^30.
	localparam int unsigned FC_W    = $clog2(FRAME_SAMPLES + 1);
	localparam int unsigned SUM_W   = SQ_W + FC_W - 1;
	localparam int unsigned PROD_W  = THR_W + FC_W;
	localparam logic [FC_W-1:0] LAST_CNT = FC_W'(FRAME_SAMPLES - 1);
	localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(evs_pkg::FIFO_DEPTH);

	function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
		input logic [CNT_W-1:0] b);
		logic [CNT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
	endfunction

	// Configuration registers.
	logic [THR_W-1:0] thr_q;
	logic [CNT_W-1:0] sil_lim_q;
	logic [CNT_W-1:0] max_seg_q;
	logic [CNT_W-1:0] min_seg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q     <= evs_pkg::THRESHOLD_RST;
			sil_lim_q <= evs_pkg::SILENCE_RST;
			max_seg_q <= evs_pkg::MAX_SEGMENT_RST;
			min_seg_q <= evs_pkg::MIN_SEGMENT_RST;
		end else if (cfg_we) begin
			unique case (evs_pkg::reg_index_t'(cfg_index))
				evs_pkg::REG_ENERGY_THRESHOLD: thr_q     <= cfg_data[THR_W-1:0];
				evs_pkg::REG_SILENCE_SAMPLES:  sil_lim_q <= cfg_data[CNT_W-1:0];
				evs_pkg::REG_MAX_SEGMENT:      max_seg_q <= cfg_data[CNT_W-1:0];
				evs_pkg::REG_MIN_SEGMENT:      min_seg_q <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Flow control. Every accepted sample reserves one queue slot. The reservation is released
	// when the sample turns out not to close a frame, or when its result leaves the queue.
	logic             in_xfer;
	logic             out_xfer;
	logic             drop;
	logic [OCC_W-1:0] occ_q;

	assign audio.ready = (occ_q < OCC_FULL);
	assign in_xfer     = audio.valid && audio.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else begin
			occ_q <= occ_q + OCC_W'(in_xfer) - OCC_W'(drop) - OCC_W'(out_xfer);
		end
	end

	// Stage 1: input register.
	logic                        valid_s1;
	logic [evs_pkg::SAMPLE_W-1:0] sample_s1;
	logic                        frame_end_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_xfer;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			sample_s1    <= audio.sample;
			frame_end_s1 <= audio.frame_end;
		end
	end

	// Stage 2: magnitude and square. The magnitude of -32768 is 32768, which still fits.
	logic [MAG_W-1:0]   mag;
	logic [2*MAG_W-1:0] sq_full;
	logic               valid_s2;
	logic [SQ_W-1:0]    sq_s2;
	logic               frame_end_s2;

	assign mag     = sample_s1[MAG_W-1] ? (~sample_s1 + MAG_W'(1)) : sample_s1;
	assign sq_full = mag * mag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			sq_s2        <= sq_full[SQ_W-1:0];
			frame_end_s2 <= frame_end_s1;
		end
	end

	// Stage 3: frame accumulator. A frame closes on frame_end or on its last allowed sample.
	logic [SUM_W-1:0] energy_sum_q;
	logic [FC_W-1:0]  frame_count_q;
	logic [SUM_W-1:0] sum_next;
	logic [FC_W-1:0]  cnt_next;
	logic             close;
	logic             valid_s3;
	logic [SUM_W-1:0] sum_s3;
	logic [FC_W-1:0]  n_s3;

	assign sum_next = energy_sum_q + SUM_W'(sq_s2);
	assign cnt_next = frame_count_q + FC_W'(1);
	assign close    = frame_end_s2 || (frame_count_q == LAST_CNT);
	assign drop     = valid_s2 && !close;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			energy_sum_q  <= '0;
			frame_count_q <= '0;
			valid_s3      <= 1'b0;
		end else begin
			valid_s3 <= valid_s2 && close;
			if (valid_s2) begin
				if (close) begin
					energy_sum_q  <= '0;
					frame_count_q <= '0;
				end else begin
					energy_sum_q  <= sum_next;
					frame_count_q <= cnt_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && close) begin
			sum_s3 <= sum_next;
			n_s3   <= cnt_next;
		end
	end

	// Stage 4: threshold scaled by the frame's sample count.
	logic              valid_s4;
	logic [PROD_W-1:0] prod_s4;
	logic [SUM_W-1:0]  sum_s4;
	logic [FC_W-1:0]   n_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s3) begin
			prod_s4 <= PROD_W'(thr_q) * PROD_W'(n_s3);
			sum_s4  <= sum_s3;
			n_s4    <= n_s3;
		end
	end

	// Stage 5: energy compare.
	logic            valid_s5;
	logic            speech_s5;
	logic [FC_W-1:0] n_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else begin
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s4) begin
			speech_s5 <= (PROD_W'(sum_s4) > prod_s4);
			n_s5      <= n_s4;
		end
	end

	// Stage 6: segment state. One closed frame is handled per cycle, so back-to-back
	// single-sample frames see each other's updates.
	logic             in_speech_q;
	logic [CNT_W-1:0] silence_count_q;
	logic [CNT_W-1:0] segment_count_q;
	logic             in_speech_n;
	logic [CNT_W-1:0] silence_n;
	logic [CNT_W-1:0] segment_n;
	logic [CNT_W-1:0] n_ext;
	evs_pkg::event_t  ev_n;
	evs_pkg::result_t res_n;

	assign n_ext = CNT_W'(n_s5);

	always_comb begin
		in_speech_n = in_speech_q;
		silence_n   = silence_count_q;
		segment_n   = segment_count_q;
		ev_n        = evs_pkg::EV_IDLE;
		if (speech_s5) begin
			// Onset restarts the segment; speech also clears the trailing silence.
			in_speech_n = 1'b1;
			ev_n        = in_speech_q ? evs_pkg::EV_RECORDING : evs_pkg::EV_ONSET;
			silence_n   = '0;
			segment_n   = sat_add(in_speech_q ? segment_count_q : '0, n_ext);
		end else if (in_speech_q) begin
			segment_n = sat_add(segment_count_q, n_ext);
			silence_n = sat_add(silence_count_q, n_ext);
			ev_n      = evs_pkg::EV_RECORDING;
			if (silence_n >= sil_lim_q) begin
				in_speech_n = 1'b0;
				ev_n        = (segment_n < min_seg_q) ? evs_pkg::EV_SHORT : evs_pkg::EV_READY;
			end
		end
		// A segment that reaches the length limit is cut here, whatever happened above.
		if (in_speech_n && (segment_n >= max_seg_q)) begin
			in_speech_n = 1'b0;
			ev_n        = evs_pkg::EV_MAXLEN;
		end
		res_n.event_res       = ev_n;
		res_n.frame_is_speech = speech_s5;
		res_n.segment_length  = (ev_n == evs_pkg::EV_IDLE) ? '0 : segment_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_speech_q     <= 1'b0;
			silence_count_q <= '0;
			segment_count_q <= '0;
		end else if (valid_s5) begin
			in_speech_q     <= in_speech_n;
			silence_count_q <= silence_n;
			segment_count_q <= segment_n;
		end
	end

	// Result queue. It cannot overflow: the reservation count bounds everything in flight.
	evs_pkg::result_t     fifo_q [evs_pkg::FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_ptr_q;
	logic [FIFO_AW-1:0]   rd_ptr_q;
	logic [OCC_W-1:0]     fifo_cnt_q;
	evs_pkg::result_t     head;

	assign out_xfer = result.valid && result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			fifo_cnt_q <= '0;
		end else begin
			if (valid_s5) begin
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			end
			if (out_xfer) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			fifo_cnt_q <= fifo_cnt_q + OCC_W'(valid_s5) - OCC_W'(out_xfer);
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s5) begin
			fifo_q[wr_ptr_q] <= res_n;
		end
	end

	assign head                   = fifo_q[rd_ptr_q];
	assign result.valid           = (fifo_cnt_q != '0);
	assign result.event_res       = head.event_res;
	assign result.frame_is_speech = head.frame_is_speech;
	assign result.segment_length  = head.segment_length;

endmodule
